FILE: sv/gsrp_pkg.sv
// shared types, register codes and bcd helpers for the serial rtc gpio port
`default_nettype none

package gsrp_pkg;

	localparam int PORT_W   = 4;
	localparam int POS_W    = 7;
	localparam int CMD_W    = 8;
	localparam int LATCH_W  = 56;
	localparam int CTRL_W   = 8;
	localparam int WVAL_W   = 16;

	localparam logic [POS_W-1:0] POS_MAX = 7'd127;
	localparam logic [POS_W-1:0] POS_CMD_END = 7'd8;
	localparam logic [POS_W-1:0] POS_LATCH_END = 7'd56;

	localparam logic [3:0] CMD_NO_FLIP = 4'h6;
	localparam int HOUR_MODE_BIT = 6;

	localparam int PIN_SCK = 0;
	localparam int PIN_SIO = 1;
	localparam int PIN_CS  = 2;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SEL_DATA      = 2'd0,
		SEL_DIRECTION = 2'd1,
		SEL_RD_ENABLE = 2'd2,
		SEL_UNMAPPED  = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_CMD   = 2'd1,
		PH_READ  = 2'd2,
		PH_WRITE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		RTC_REG_CONTROL  = 3'd1,
		RTC_REG_DATETIME = 3'd2,
		RTC_REG_TIME     = 3'd3
	} rtc_reg_t;

	typedef struct packed {
		logic              op;
		logic [1:0]        reg_sel;
		logic [WVAL_W-1:0] write_value;
		logic [6:0]        year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [2:0]        weekday;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} item_t;

	typedef struct packed {
		logic [PORT_W-1:0] read_data;
		logic [PORT_W-1:0] pin_state;
		logic [1:0]        phase;
	} result_t;

	// tens and units of a value below 128, tens by reciprocal multiply
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [17:0] prod;
		logic [3:0]  tens;
		logic [6:0]  units;
		prod  = 18'(v) * 18'd205;
		tens  = prod[14:11];
		units = v - (7'(tens) * 7'd10);
		return {tens, units[3:0]};
	endfunction

	function automatic logic [7:0] flip8(input logic [7:0] a);
		logic [7:0] b;
		for (int i = 0; i < 8; i++) begin
			b[7-i] = a[i];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: sv/gsrp_engine.sv
// port registers and serial rtc transfer logic, one item per step
`default_nettype none

module gsrp_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire gsrp_pkg::item_t               item,
	input  wire logic [gsrp_pkg::CTRL_W-1:0]   rtc_control,
	output      gsrp_pkg::result_t             result
);
	import gsrp_pkg::*;

	logic [PORT_W-1:0]  port_q, port_d, port_drv;
	logic [PORT_W-1:0]  dir_q, dir_d;
	logic               re_q, re_d;
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d, pos_inc;
	logic [CMD_W-1:0]   cmd_q, cmd_d, cmd_acc, cmd_fin;
	logic [LATCH_W-1:0] latch_q, latch_d, latch_new;

	logic drive, rise_cs, fall_cs, rise_sck, cmd_done, out_bit;
	logic [4:0]  hr;
	logic [23:0] tim;
	logic [31:0] date;
	logic [PORT_W-1:0] rd;

	assign drive = (item.op == OP_WRITE) && (item.reg_sel == SEL_DATA);
	assign port_drv = (port_q & ~dir_q) | (item.write_value[PORT_W-1:0] & dir_q);
	assign rise_cs  = drive && !port_q[PIN_CS] && port_drv[PIN_CS];
	assign fall_cs  = drive && port_q[PIN_CS] && !port_drv[PIN_CS];
	assign rise_sck = drive && !port_q[PIN_SCK] && port_drv[PIN_SCK];

	assign pos_inc  = pos_q + 7'd1;
	assign cmd_acc  = cmd_q | (8'(port_drv[PIN_SIO]) << pos_q[2:0]);
	assign cmd_fin  = (cmd_acc[7:4] != CMD_NO_FLIP) ? flip8(cmd_acc) : cmd_acc;
	assign cmd_done = rise_sck && (pos_inc >= POS_CMD_END);

	always_comb begin
		if (rtc_control[HOUR_MODE_BIT]) begin
			hr = item.hour;
		end else if (item.hour >= 5'd24) begin
			hr = item.hour - 5'd24;
		end else if (item.hour >= 5'd12) begin
			hr = item.hour - 5'd12;
		end else begin
			hr = item.hour;
		end
	end

	assign date = {to_bcd(7'(item.weekday)), to_bcd(7'(item.day)),
		to_bcd(7'(item.month)), to_bcd(item.year)};
	assign tim  = {to_bcd(7'(item.second)), to_bcd(7'(item.minute)), to_bcd(7'(hr))};

	always_comb begin
		unique case (cmd_fin[3:1])
			RTC_REG_CONTROL:  latch_new = LATCH_W'(rtc_control);
			RTC_REG_DATETIME: latch_new = {tim, date};
			RTC_REG_TIME:     latch_new = LATCH_W'(tim);
			default:          latch_new = '0;
		endcase
	end

	assign out_bit = (pos_q < POS_LATCH_END) ? latch_q[pos_q[5:0]] : 1'b0;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_READY: if (rise_cs && port_drv[PIN_SCK]) phase_d = PH_CMD;
			PH_CMD: begin
				if (cmd_done) begin
					phase_d = cmd_fin[0] ? PH_READ : PH_WRITE;
				end
			end
			PH_READ:  if (fall_cs) phase_d = PH_READY;
			PH_WRITE: if (fall_cs) phase_d = PH_READY;
			default:  phase_d = PH_READY;
		endcase
	end

	// port and transfer data
	always_comb begin
		port_d  = drive ? port_drv : port_q;
		dir_d   = dir_q;
		re_d    = re_q;
		pos_d   = pos_q;
		cmd_d   = cmd_q;
		latch_d = latch_q;
		if (item.op == OP_WRITE) begin
			case (item.reg_sel)
				SEL_DIRECTION: dir_d = item.write_value[PORT_W-1:0];
				SEL_RD_ENABLE: re_d  = item.write_value[0];
				default: ;
			endcase
		end
		unique case (phase_q)
			PH_READY: begin
				if (rise_cs && port_drv[PIN_SCK]) begin
					pos_d   = '0;
					cmd_d   = '0;
					latch_d = '0;
				end
			end
			PH_CMD: begin
				if (rise_sck) begin
					if (cmd_done) begin
						pos_d = '0;
						cmd_d = cmd_fin;
						if (cmd_fin[0]) latch_d = latch_new;
					end else begin
						pos_d = pos_inc;
						cmd_d = cmd_acc;
					end
				end
			end
			PH_READ: begin
				if (rise_sck) begin
					port_d[PIN_SIO] = out_bit;
					if (pos_q < POS_MAX) pos_d = pos_inc;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rd = '0;
		if (item.op == OP_READ && re_q) begin
			case (item.reg_sel)
				SEL_DATA:      rd = port_q & ~dir_q;
				SEL_DIRECTION: rd = dir_q;
				SEL_RD_ENABLE: rd = PORT_W'(re_q);
				default:       rd = '0;
			endcase
		end
	end

	assign result.read_data = rd;
	assign result.pin_state = port_d;
	assign result.phase     = phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q  <= '0;
			dir_q   <= '0;
			re_q    <= 1'b0;
			phase_q <= PH_READY;
			pos_q   <= '0;
			cmd_q   <= '0;
			latch_q <= '0;
		end else if (step) begin
			port_q  <= port_d;
			dir_q   <= dir_d;
			re_q    <= re_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cmd_q   <= cmd_d;
			latch_q <= latch_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/gpio_serial_rtc_port.sv
// top level of the cartridge gpio port fronting a three-wire serial rtc
//
// each bus access enters as one item on the item channel (item_valid /
// item_stall) and gives exactly one result item on the result channel
// (result_valid / result_stall): read data, pin state after the access and
// the transfer phase.
// an item is registered on entry and worked on against the port state once
// it advances, which waits while a held result is stalled; its result is then
// registered and drives result_valid. one item is taken every cycle while the
// receiver keeps result_stall low.
// when the receiver stalls, the waiting result holds and the one item in the
// input register waits behind it; item_stall rises only once both are full.
// the clock control byte is written through ctrl_wr_en / ctrl_wr_data, by the
// user only while no access is in flight; the block does not enforce this.
// reset clears the port data, direction and read-enable bits, returns the
// transfer to the ready phase, clears the command, shift latch and control
// byte, and empties both registers.
`default_nettype none

module gpio_serial_rtc_port (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output      logic        item_stall,
	input  wire logic        op,
	input  wire logic [1:0]  reg_sel,
	input  wire logic [15:0] write_value,
	input  wire logic [6:0]  year,
	input  wire logic [3:0]  month,
	input  wire logic [4:0]  day,
	input  wire logic [2:0]  weekday,
	input  wire logic [4:0]  hour,
	input  wire logic [5:0]  minute,
	input  wire logic [5:0]  second,
	output      logic        result_valid,
	input  wire logic        result_stall,
	output      logic [3:0]  read_data,
	output      logic [3:0]  pin_state,
	output      logic [1:0]  phase,
	input  wire logic        ctrl_wr_en,
	input  wire logic [7:0]  ctrl_wr_data
);
	import gsrp_pkg::*;

	logic              vld_s1, vld_s2, adv, load;
	item_t             item_s1;
	result_t           res_comb, res_s2;
	logic [CTRL_W-1:0] rtc_control_q;

	assign adv        = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !adv;
	assign load       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			rtc_control_q <= '0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (!result_stall) begin
				vld_s2 <= 1'b0;
			end
			if (ctrl_wr_en) begin
				rtc_control_q <= ctrl_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{op: op, reg_sel: reg_sel, write_value: write_value,
				year: year, month: month, day: day, weekday: weekday,
				hour: hour, minute: minute, second: second};
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	gsrp_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.item        (item_s1),
		.rtc_control (rtc_control_q),
		.result      (res_comb)
	);

	assign result_valid = vld_s2;
	assign read_data    = res_s2.read_data;
	assign pin_state    = res_s2.pin_state;
	assign phase        = res_s2.phase;

endmodule

`default_nettype wire
